FILE: rtl/fmpf_pkg.sv
`timescale 1ns / 1ps

package fmpf_pkg;

    localparam int NUM_ABBR  = 11;
    localparam int HIST_BYTES = 6;
    localparam int WIN_W     = 8 * (HIST_BYTES + 1);
    localparam int POS_W     = 12;

    typedef logic [WIN_W-1:0] window_t;
    typedef logic [2:0]       abbr_len_t;

    // Abbreviation text, right-aligned: the final byte sits in the low byte.
    localparam window_t ABBR_TEXT [NUM_ABBR] = '{
        window_t'("n."),
        window_t'("prep."),
        window_t'("v.t."),
        window_t'("adv."),
        window_t'("pl."),
        window_t'("p.p."),
        window_t'("a."),
        window_t'("v.i."),
        window_t'("pron."),
        window_t'("conj."),
        window_t'("interj.")
    };

    localparam abbr_len_t ABBR_LEN [NUM_ABBR] = '{
        3'd2, 3'd5, 3'd4, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd5, 3'd5, 3'd7
    };

    localparam window_t ABBR_MASK [NUM_ABBR] = '{
        window_t'(56'h0000_0000_00FF_FF),
        window_t'(56'h0000_FFFF_FFFF_FF),
        window_t'(56'h0000_00FF_FFFF_FF),
        window_t'(56'h0000_00FF_FFFF_FF),
        window_t'(56'h0000_0000_FFFF_FF),
        window_t'(56'h0000_00FF_FFFF_FF),
        window_t'(56'h0000_0000_00FF_FF),
        window_t'(56'h0000_00FF_FFFF_FF),
        window_t'(56'h0000_FFFF_FFFF_FF),
        window_t'(56'h0000_FFFF_FFFF_FF),
        window_t'(56'hFFFF_FFFF_FFFF_FF)
    };

endpackage

FILE: rtl/first_marker_position_finder.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake         | Payload
// in      | receive   | in_valid/in_stall  | ch[7:0], line_end
// out     | send      | out_valid/out_stall | found, position[11:0], too_long
//
// One input beat per cycle, sustained while in_stall holds no line_end beat;
// a beat is registered, then matched against the six-byte history in the next
// cycle, and a line_end beat's result then goes on into the output register.
// Reset clears the line state and both pipeline valids.
// out_stall only holds back a line_end beat waiting in the input register;
// byte beats keep flowing while a result waits to be taken.
module first_marker_position_finder #(
    parameter int MAX_LINE = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               ch,
    input  logic                     line_end,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     found,
    output logic [fmpf_pkg::POS_W-1:0] position,
    output logic                     too_long
);

    localparam int CNT_W = $clog2(MAX_LINE + 1);

    logic                    s1_valid_reg, s1_valid_next;
    logic [7:0]              s1_ch_reg;
    logic                    s1_end_reg;
    logic                    s1_go;
    logic                    in_accept;
    logic                    process;

    logic [8*fmpf_pkg::HIST_BYTES-1:0] recent_reg, recent_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        best_reg, best_next;
    logic                    have_reg, have_next;
    logic                    ovf_reg, ovf_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg, found_next;
    logic [fmpf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                    too_long_reg, too_long_next;

    fmpf_pkg::window_t       window;
    logic [7:0]              hit_len;
    logic                    any_hit;
    fmpf_pkg::abbr_len_t     long_len;
    logic [CNT_W-1:0]        start;
    logic [31:0]             best_ext;

    // A result can only leave stage one when the output register is free.
    assign s1_go     = !s1_end_reg || !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;
    assign process   = s1_valid_reg && s1_go;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ch_reg  <= ch;
            s1_end_reg <= line_end;
        end
    end

    // Match every abbreviation that ends on the current byte.
    always_comb
    begin
        window  = {recent_reg, s1_ch_reg};
        hit_len = '0;
        for (int a = 0; a < fmpf_pkg::NUM_ABBR; a++)
        begin
            if (((window & fmpf_pkg::ABBR_MASK[a]) == fmpf_pkg::ABBR_TEXT[a]) &&
                (count_reg >= CNT_W'(fmpf_pkg::ABBR_LEN[a] - 3'd1)))
            begin
                hit_len[fmpf_pkg::ABBR_LEN[a]] = 1'b1;
            end
        end
    end

    // The longest hit starts earliest.
    always_comb
    begin
        any_hit  = 1'b1;
        long_len = 3'd2;
        if (hit_len[7])
        begin
            long_len = 3'd7;
        end
        else if (hit_len[5])
        begin
            long_len = 3'd5;
        end
        else if (hit_len[4])
        begin
            long_len = 3'd4;
        end
        else if (hit_len[3])
        begin
            long_len = 3'd3;
        end
        else if (hit_len[2])
        begin
            long_len = 3'd2;
        end
        else
        begin
            any_hit = 1'b0;
        end
        start = count_reg - CNT_W'(long_len - 3'd1);
    end

    always_comb
    begin
        recent_next = recent_reg;
        count_next  = count_reg;
        best_next   = best_reg;
        have_next   = have_reg;
        ovf_next    = ovf_reg;
        if (process)
        begin
            if (s1_end_reg)
            begin
                recent_next = '0;
                count_next  = '0;
                best_next   = '0;
                have_next   = 1'b0;
                ovf_next    = 1'b0;
            end
            else if (count_reg >= CNT_W'(MAX_LINE))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                if (any_hit && (!have_reg || start < best_reg))
                begin
                    best_next = start;
                    have_next = 1'b1;
                end
                recent_next = window[8*fmpf_pkg::HIST_BYTES-1:0];
                count_next  = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
            count_reg  <= '0;
            best_reg   <= '0;
            have_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            recent_reg <= recent_next;
            count_reg  <= count_next;
            best_reg   <= best_next;
            have_reg   <= have_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign best_ext = 32'(best_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        too_long_next  = too_long_reg;
        if (process && s1_end_reg)
        begin
            out_valid_next = 1'b1;
            found_next     = have_reg;
            pos_next       = have_reg ? best_ext[fmpf_pkg::POS_W-1:0] : '0;
            too_long_next  = ovf_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        too_long_reg <= too_long_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = pos_reg;
    assign too_long  = too_long_reg;

    a_result_from_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_end_reg))
        else $error("result appeared without a line_end beat");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LINE))
        else $error("byte count passed the line limit");

    a_no_position_without_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (pos_reg == '0))
        else $error("position nonzero with no match");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_end_reg && out_valid_reg))
        else $error("input stalled with nothing blocked");

endmodule
